FILE: sv/byte_offset_pixel_decoder_top_assert.svh
// Assertion macros shared by the checker.
`ifndef BYTE_OFFSET_PIXEL_DECODER_TOP_ASSERT_SVH
`define BYTE_OFFSET_PIXEL_DECODER_TOP_ASSERT_SVH

// Checked while out of reset.
`define BOPD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked through reset as well.
`define BOPD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: sv/bopd_pkg.sv
`timescale 1ns / 1ps
package bopd_pkg;

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int QUEUE_DEPTH = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_PIXELS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_LIMIT = 2'd1;

  localparam logic [24:0] FRAME_PIXELS_RST = 25'd6224001;
  localparam logic [15:0] HEADER_LIMIT_RST = 16'd2000;
  localparam logic [24:0] MAX_FRAME        = 25'd16777216;

  localparam logic [7:0]  MARKER_BYTE = 8'hD5;
  localparam logic [7:0]  ESCAPE_BYTE = 8'h80;
  localparam logic [15:0] ESCAPE_WORD = 16'h8000;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pixel_value;
    logic [23:0]        pixel_index;
    logic               last_pixel;
    logic [30:0]        max_count;
  } out_item_t;

  // decoded delta handed from front to back
  typedef struct packed {
    logic [31:0] delta;
    logic [23:0] index;
    logic        last;
  } delta_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

FILE: sv/bopd_front.sv
`timescale 1ns / 1ps
module bopd_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  bopd_pkg::in_item_t    in_item,
  input  logic [24:0]           frame_pixels,
  input  logic [15:0]           header_limit,
  output logic                  push,
  output bopd_pkg::delta_item_t push_item
);

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_BYTE   = 3'd1;
  localparam logic [2:0] PH_WORD   = 3'd2;
  localparam logic [2:0] PH_LONG   = 3'd3;
  localparam logic [2:0] PH_IDLE   = 3'd4;

  logic [2:0]  phase_r, phase_nxt, phase_c;
  logic [15:0] seen_r, seen_nxt, seen_c;
  logic [23:0] part_r, part_nxt, part_c;
  logic [1:0]  held_r, held_nxt, held_c;
  logic [23:0] cnt_r, cnt_nxt, cnt_c;

  logic        emit;
  logic [31:0] delta;
  logic [24:0] limit;
  logic        last;
  logic [15:0] word;
  logic [7:0]  b;

  assign b    = in_item.data_byte;
  assign word = {b, part_c[7:0]};

  // clamp frame size into 1 .. 2^24
  always_comb begin
    if (frame_pixels == 25'd0) begin
      limit = 25'd1;
    end else if (frame_pixels > bopd_pkg::MAX_FRAME) begin
      limit = bopd_pkg::MAX_FRAME;
    end else begin
      limit = frame_pixels;
    end
  end

  assign last = ({1'b0, cnt_c} + 25'd1) >= limit;

  always_comb begin
    // frame start wipes the frame state before the byte is looked at
    if (in_item.frame_start) begin
      phase_c = PH_HEADER;
      seen_c  = '0;
      part_c  = '0;
      held_c  = '0;
      cnt_c   = '0;
    end else begin
      phase_c = phase_r;
      seen_c  = seen_r;
      part_c  = part_r;
      held_c  = held_r;
      cnt_c   = cnt_r;
    end
    phase_nxt = phase_c;
    seen_nxt  = seen_c;
    part_nxt  = part_c;
    held_nxt  = held_c;
    cnt_nxt   = cnt_c;
    emit      = 1'b0;
    delta     = '0;
    case (phase_c)
      PH_HEADER: begin
        if (seen_c >= header_limit) begin
          phase_nxt = PH_IDLE;
        end else if (b == bopd_pkg::MARKER_BYTE) begin
          phase_nxt = PH_BYTE;
        end else begin
          seen_nxt = seen_c + 16'd1;
          if (({1'b0, seen_c} + 17'd1) >= {1'b0, header_limit}) begin
            phase_nxt = PH_IDLE;
          end
        end
      end
      PH_BYTE: begin
        if (b == bopd_pkg::ESCAPE_BYTE) begin
          phase_nxt = PH_WORD;
          part_nxt  = '0;
          held_nxt  = '0;
        end else begin
          emit  = 1'b1;
          delta = {{24{b[7]}}, b};
        end
      end
      PH_WORD: begin
        if (held_c == 2'd0) begin
          part_nxt = {16'd0, b};
          held_nxt = 2'd1;
        end else if (word == bopd_pkg::ESCAPE_WORD) begin
          phase_nxt = PH_LONG;
          part_nxt  = '0;
          held_nxt  = '0;
        end else begin
          emit  = 1'b1;
          delta = {{16{word[15]}}, word};
        end
      end
      PH_LONG: begin
        // little-endian: bytes 0..2 collect, byte 3 completes
        case (held_c)
          2'd0:    part_nxt = {part_c[23:8], b};
          2'd1:    part_nxt = {part_c[23:16], b, part_c[7:0]};
          2'd2:    part_nxt = {b, part_c[15:0]};
          default: part_nxt = part_c;
        endcase
        held_nxt = held_c + 2'd1;
        if (held_c == 2'd3) begin
          emit  = 1'b1;
          delta = {b, part_c};
        end
      end
      default: begin
        phase_nxt = phase_c;
      end
    endcase
    if (emit) begin
      cnt_nxt   = cnt_c + 24'd1;
      part_nxt  = '0;
      held_nxt  = '0;
      phase_nxt = last ? PH_IDLE : PH_BYTE;
    end
  end

  assign push            = accept && emit;
  assign push_item.delta = delta;
  assign push_item.index = cnt_c;
  assign push_item.last  = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      seen_r  <= '0;
      part_r  <= '0;
      held_r  <= '0;
      cnt_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      seen_r  <= seen_nxt;
      part_r  <= part_nxt;
      held_r  <= held_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

FILE: sv/bopd_queue.sv
`timescale 1ns / 1ps
module bopd_queue #(
  parameter int DEPTH = bopd_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  bopd_pkg::delta_item_t push_item,
  input  logic                  pop,
  output bopd_pkg::delta_item_t pop_item,
  output bopd_pkg::queue_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  bopd_pkg::delta_item_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign status.full  = (count_r == CNT_FULL);
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_item     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

FILE: sv/bopd_back.sv
`timescale 1ns / 1ps
module bopd_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  bopd_pkg::delta_item_t q_item,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output bopd_pkg::out_item_t   out_data
);

  logic [31:0] prev_r, base, value;
  logic [30:0] max_r, max_base, max_nxt;
  logic        first;
  logic        out_valid_r;
  bopd_pkg::out_item_t out_data_r;

  // index zero opens a frame: previous pixel and maximum start from zero
  assign first    = (q_item.index == 24'd0);
  assign base     = first ? 32'd0 : prev_r;
  assign max_base = first ? 31'd0 : max_r;
  assign value    = base + q_item.delta;
  assign max_nxt  = (!value[31] && (value[30:0] > max_base)) ? value[30:0] : max_base;

  assign pop       = q_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r.pixel_value <= value;
      out_data_r.pixel_index <= q_item.index;
      out_data_r.last_pixel  <= q_item.last;
      out_data_r.max_count   <= max_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      prev_r      <= '0;
      max_r       <= '0;
    end else begin
      if (pop) begin
        out_valid_r <= 1'b1;
        prev_r      <= value;
        max_r       <= max_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

FILE: sv/byte_offset_pixel_decoder_top.sv
`timescale 1ns / 1ps
// Channel   Direction  Payload / fields                               Handshake
// in_       input      in_item_t: data_byte, frame_start              in_valid / in_ready
// out_      output     out_item_t: pixel_value, pixel_index,          out_valid / out_ready
//                      last_pixel, max_count
// cfg_      input      cfg_index (0 frame_pixels, 1 header_limit),    cfg_valid / cfg_ready
//                      cfg_data
//
// One byte is taken per cycle while in_ready is high; the pixel that a byte
// completes is registered into the queue by the front, then into out reg by the back.
// The front decoder takes one byte every clock while the queue is not full.
// Reset (rst_n low, synchronous) clears frame state, empties the queue and
// loads frame_pixels = 6224001, header_limit = 2000.
// in_ready drops only when the delta queue is full; the queue absorbs
// out_ready stalls for up to QUEUE_DEPTH pixels.
module byte_offset_pixel_decoder_top #(
  parameter int QUEUE_DEPTH = bopd_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // byte input
  input  logic                              in_valid,
  output logic                              in_ready,
  input  bopd_pkg::in_item_t                in_data,
  // pixel output
  output logic                              out_valid,
  input  logic                              out_ready,
  output bopd_pkg::out_item_t               out_data,
  // register writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bopd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bopd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [24:0] frame_pixels_r;
  logic [15:0] header_limit_r;

  logic                    in_accept;
  logic                    push;
  logic                    pop;
  bopd_pkg::delta_item_t   push_item;
  bopd_pkg::delta_item_t   pop_item;
  bopd_pkg::queue_status_t q_status;

  // register file: writes are always taken; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_pixels_r <= bopd_pkg::FRAME_PIXELS_RST;
      header_limit_r <= bopd_pkg::HEADER_LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        bopd_pkg::REG_FRAME_PIXELS: frame_pixels_r <= cfg_data[24:0];
        bopd_pkg::REG_HEADER_LIMIT: header_limit_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // front stalls only when the queue has no room for a possible pixel
  assign in_ready  = !q_status.full;
  assign in_accept = in_valid && in_ready;

  bopd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_accept),
    .in_item      (in_data),
    .frame_pixels (frame_pixels_r),
    .header_limit (header_limit_r),
    .push         (push),
    .push_item    (push_item)
  );

  bopd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .status    (q_status)
  );

  // back end: running value, running max, output register
  bopd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (!q_status.empty),
    .q_item    (pop_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: sv/bopd_checker.sv
`timescale 1ns / 1ps
`include "byte_offset_pixel_decoder_top_assert.svh"
module bopd_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input bopd_pkg::in_item_t              in_data,
  input logic                            out_valid,
  input logic                            out_ready,
  input bopd_pkg::out_item_t             out_data,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [bopd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [bopd_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic unused_ok;
  assign unused_ok = ^{in_valid, in_data, cfg_valid, cfg_index, cfg_data};

  `BOPD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "out_valid dropped while stalled")
  `BOPD_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_data), "out_data changed while stalled")
  `BOPD_ASSERT(a_max_bound, out_valid && !out_data.pixel_value[31] |-> out_data.max_count >= out_data.pixel_value[30:0], "max_count below a nonnegative pixel")
  `BOPD_ASSERT(a_first_max, out_valid && out_data.pixel_index == 24'd0 && out_data.pixel_value[31] |-> out_data.max_count == 31'd0, "first pixel max not from zero")
  `BOPD_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid && in_ready && cfg_ready, "not idle after reset")

endmodule

bind byte_offset_pixel_decoder_top bopd_checker u_bopd_checker (.*);
